@@ rtl/m3i_pkg.sv @@
// ---------------------------------------------------------------------------
// m3i_pkg
// shared constants, cofactor index tables and a width helper for the
// 3x3 matrix inverse pipeline
// ---------------------------------------------------------------------------
`default_nettype none

package m3i_pkg;

  localparam int IN_WIDTH_DEF  = 16;
  localparam int OUT_WIDTH_DEF = 32;
  localparam int IN_FRAC       = 12;
  localparam int OUT_FRAC      = 16;
  localparam int FRAC_SHIFT    = IN_FRAC + OUT_FRAC;
  localparam int THR_WIDTH     = 48;
  localparam int DIM           = 3;
  localparam int N_ELEM        = DIM * DIM;

  // config port
  localparam int PADDR_WIDTH = 4;
  localparam int PDATA_WIDTH = 64;
  localparam logic [0:0] REG_DET_THRESHOLD = 1'b0;

  // cofactor i = e[PA]*e[PB] - e[NA]*e[NB], elements row-major
  localparam int unsigned COF_PA [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned COF_PB [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned COF_NA [N_ELEM] = '{5, 1, 2, 3, 2, 0, 6, 0, 1};
  localparam int unsigned COF_NB [N_ELEM] = '{7, 8, 4, 8, 6, 5, 4, 7, 3};

  // width of the rounded, scaled dividend
  function automatic int num_width(input int w, input int o);
    int a;
    int b;
    a = 2 * w + FRAC_SHIFT;
    b = 3 * w - 1;
    if (b > a) a = b;
    a = a + 1;
    if (a < o + 1) a = o + 1;
    return a;
  endfunction

endpackage

`default_nettype wire

@@ rtl/matrix3x3_inverse.sv @@
// ---------------------------------------------------------------------------
// matrix3x3_inverse
// pipelined 3x3 inverse by the adjugate method, Q4.12 in, Q16.16 out
// ---------------------------------------------------------------------------
//
//  port group   dir  contents
//  s_axis_*     in   one matrix per transaction, nine entries row-major
//  m_axis_*     out  one inverse per transaction, nine entries + singular flag
//  apb (p*)     in   det_threshold at byte address 0 (64-bit data)
//
//  stages: 2 cofactor, 4 determinant, one overflow, one per quotient bit of
//  the nine-lane divider, and the output register
//  throughput is one matrix per clock: a new matrix is taken every cycle
//  unless a stalled output has filled every stage
//  every stage has its own valid bit and advances when its successor is
//  empty or moving, so bubbles close up behind a stalled output
//  rst clears only the valid bits and det_threshold
//
`default_nettype none

module matrix3x3_inverse import m3i_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2
  input  logic [((N_ELEM*IN_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, ... inv_r2c2
  output logic [((N_ELEM*OUT_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // is_singular
  output logic [0:0]                                 m_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [PADDR_WIDTH-1:0]                     paddr,
  input  logic [PDATA_WIDTH-1:0]                     pwdata,
  output logic [PDATA_WIDTH-1:0]                     prdata,
  output logic                                       pready
);

  localparam int CW  = 2 * IN_WIDTH + 1;
  localparam int DMW = 3 * IN_WIDTH;
  localparam int NW  = num_width(IN_WIDTH, OUT_WIDTH);
  localparam int OTW = ((N_ELEM*OUT_WIDTH+7)/8)*8;

  logic [THR_WIDTH-1:0]       det_threshold;
  logic                       reg_hit;

  // cofactor -> determinant
  logic                       cf_valid, cf_ready;
  logic [N_ELEM*CW-1:0]       cf_cof;
  logic [DIM*IN_WIDTH-1:0]    cf_row0;

  // determinant -> divider
  logic                       dt_valid, dt_ready;
  logic [N_ELEM*NW-1:0]       dt_num;
  logic [N_ELEM-1:0]          dt_cneg;
  logic [DMW-1:0]             dt_dm;
  logic                       dt_dneg, dt_sing;

  logic [N_ELEM*OUT_WIDTH-1:0] inv;
  logic                        sing;

  // register file: one 48-bit threshold, word index in paddr[3]
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_WIDTH-1:3] == REG_DET_THRESHOLD);
  assign prdata  = reg_hit ? PDATA_WIDTH'(det_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      det_threshold <= pwdata[THR_WIDTH-1:0];
    end
  end

  m3i_cofactor #(.IN_WIDTH(IN_WIDTH)) u_cofactor (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .mat       (s_axis_tdata[N_ELEM*IN_WIDTH-1:0]),
    .out_valid (cf_valid),
    .out_ready (cf_ready),
    .cof       (cf_cof),
    .row0      (cf_row0)
  );

  m3i_det #(.IN_WIDTH(IN_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_det (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cf_valid),
    .in_ready  (cf_ready),
    .cof       (cf_cof),
    .row0      (cf_row0),
    .thr       (det_threshold),
    .out_valid (dt_valid),
    .out_ready (dt_ready),
    .num       (dt_num),
    .cneg      (dt_cneg),
    .dm        (dt_dm),
    .dneg      (dt_dneg),
    .sing      (dt_sing)
  );

  m3i_divider #(.IN_WIDTH(IN_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dt_valid),
    .in_ready  (dt_ready),
    .num       (dt_num),
    .cneg      (dt_cneg),
    .dm        (dt_dm),
    .dneg      (dt_dneg),
    .sing      (dt_sing),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .inv       (inv),
    .sing_out  (sing)
  );

  // pad the inverse out to whole bytes
  assign m_axis_tdata = OTW'(inv);
  assign m_axis_tuser = sing;

endmodule

`default_nettype wire

@@ rtl/m3i_cofactor.sv @@
// ---------------------------------------------------------------------------
// m3i_cofactor
// two-stage pipeline: eighteen products, then the nine adjugate cofactors
// ---------------------------------------------------------------------------
`default_nettype none

module m3i_cofactor import m3i_pkg::*; #(
  parameter int IN_WIDTH = IN_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [N_ELEM*IN_WIDTH-1:0]           mat,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [N_ELEM*(2*IN_WIDTH+1)-1:0]     cof,
  output logic [DIM*IN_WIDTH-1:0]              row0
);

  localparam int W  = IN_WIDTH;
  localparam int PW = 2 * W;
  localparam int CW = 2 * W + 1;

  logic signed [W-1:0]  e  [N_ELEM];
  logic signed [PW-1:0] pp [N_ELEM];
  logic signed [PW-1:0] pn [N_ELEM];
  logic signed [CW-1:0] cq [N_ELEM];
  logic [DIM*W-1:0]     r0a;
  logic [DIM*W-1:0]     r0b;
  logic v1, v2, en1, en2;

  assign en2       = !v2 || out_ready;
  assign en1       = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v2;
  assign row0      = r0b;

  always_comb begin
    for (int i = 0; i < N_ELEM; i++) begin
      e[i] = mat[i*W +: W];
      cof[i*CW +: CW] = cq[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < N_ELEM; i++) begin
        pp[i] <= e[COF_PA[i]] * e[COF_PB[i]];
        pn[i] <= e[COF_NA[i]] * e[COF_NB[i]];
      end
      r0a <= mat[DIM*W-1:0];
    end
    if (en2) begin
      for (int i = 0; i < N_ELEM; i++) begin
        cq[i] <= CW'(pp[i]) - CW'(pn[i]);
      end
      r0b <= r0a;
    end
  end

endmodule

`default_nettype wire

@@ rtl/m3i_det.sv @@
// ---------------------------------------------------------------------------
// m3i_det
// four-stage pipeline: determinant products, sum, magnitudes, then the
// singular test and the rounded dividends
// ---------------------------------------------------------------------------
`default_nettype none

module m3i_det import m3i_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [N_ELEM*(2*IN_WIDTH+1)-1:0]               cof,
  input  logic [DIM*IN_WIDTH-1:0]                        row0,
  input  logic [THR_WIDTH-1:0]                           thr,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [N_ELEM*num_width(IN_WIDTH,OUT_WIDTH)-1:0] num,
  output logic [N_ELEM-1:0]                              cneg,
  output logic [3*IN_WIDTH-1:0]                          dm,
  output logic                                           dneg,
  output logic                                           sing
);

  localparam int W   = IN_WIDTH;
  localparam int CW  = 2 * W + 1;
  localparam int CMW = 2 * W;
  localparam int DW  = 3 * W + 3;
  localparam int DMW = 3 * W;
  localparam int NW  = num_width(IN_WIDTH, OUT_WIDTH);
  localparam int CPW = (DMW > THR_WIDTH) ? DMW : THR_WIDTH;

  logic signed [W-1:0]  r0e [DIM];
  logic signed [CW-1:0] ci  [N_ELEM];
  logic signed [DW-1:0] dp  [DIM];
  logic signed [CW-1:0] c1  [N_ELEM];
  logic signed [DW-1:0] det;
  logic signed [CW-1:0] c2  [N_ELEM];
  logic [DMW-1:0]       dmag;
  logic                 dn3;
  logic [CMW-1:0]       cm  [N_ELEM];
  logic [N_ELEM-1:0]    cn3;
  logic [NW-1:0]        nr  [N_ELEM];
  logic [DMW-1:0]       dm4;
  logic                 dn4, sg4;
  logic [N_ELEM-1:0]    cn4;
  logic [3:0]           v;
  logic [3:0]           en;

  assign en[3]     = !v[3] || out_ready;
  assign en[2]     = !v[2] || en[3];
  assign en[1]     = !v[1] || en[2];
  assign en[0]     = !v[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = v[3];
  assign dm        = dm4;
  assign dneg      = dn4;
  assign sing      = sg4;
  assign cneg      = cn4;

  always_comb begin
    for (int j = 0; j < DIM; j++) r0e[j] = row0[j*W +: W];
    for (int i = 0; i < N_ELEM; i++) begin
      ci[i] = cof[i*CW +: CW];
      num[i*NW +: NW] = nr[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < 4; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    // expansion along row 0 uses cofactors 0, 3 and 6
    if (en[0]) begin
      for (int j = 0; j < DIM; j++) dp[j] <= DW'(r0e[j] * ci[DIM*j]);
      c1 <= ci;
    end
    if (en[1]) begin
      det <= dp[0] + dp[1] + dp[2];
      c2  <= c1;
    end
    if (en[2]) begin
      dn3  <= det[DW-1];
      dmag <= DMW'(det[DW-1] ? -det : det);
      for (int i = 0; i < N_ELEM; i++) begin
        cn3[i] <= c2[i][CW-1];
        cm[i]  <= CMW'(c2[i][CW-1] ? -c2[i] : c2[i]);
      end
    end
    if (en[3]) begin
      sg4 <= (CPW'(dmag) <= CPW'(thr)) || (dmag == '0);
      dm4 <= dmag;
      dn4 <= dn3;
      cn4 <= cn3;
      for (int i = 0; i < N_ELEM; i++) begin
        nr[i] <= (NW'(cm[i]) << FRAC_SHIFT) + NW'(dmag >> 1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/m3i_divider.sv @@
// ---------------------------------------------------------------------------
// m3i_divider
// nine-lane restoring divider: overflow test, one quotient bit per stage, then sign,
// saturation and singular zeroing into the output register
// ---------------------------------------------------------------------------
`default_nettype none

module m3i_divider import m3i_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [N_ELEM*num_width(IN_WIDTH,OUT_WIDTH)-1:0] num,
  input  logic [N_ELEM-1:0]                              cneg,
  input  logic [3*IN_WIDTH-1:0]                          dm,
  input  logic                                           dneg,
  input  logic                                           sing,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [N_ELEM*OUT_WIDTH-1:0]                    inv,
  output logic                                           sing_out
);

  localparam int O   = OUT_WIDTH;
  localparam int DMW = 3 * IN_WIDTH;
  localparam int NW  = num_width(IN_WIDTH, OUT_WIDTH);
  localparam int HW  = NW - O;
  localparam int ST  = O + 2;

  logic [HW-1:0]  nh  [N_ELEM];
  logic [O-1:0]   nl  [N_ELEM];
  logic [DMW-1:0] p   [O+1][N_ELEM];
  logic [O-1:0]   lo  [O+1][N_ELEM];
  logic [O-1:0]   q   [O+1][N_ELEM];
  logic           ovf [O+1][N_ELEM];
  logic           cn  [O+1][N_ELEM];
  logic [DMW-1:0] dmr [O+1];
  logic           dn  [O+1];
  logic           sg  [O+1];
  logic [O-1:0]   res [N_ELEM];
  logic [O-1:0]   ir  [N_ELEM];
  logic           sgr;
  logic [ST-1:0]  v;
  logic [ST-1:0]  en;

  localparam logic [O-1:0] LIM = {1'b1, {(O-1){1'b0}}};

  assign in_ready  = en[0];
  assign out_valid = v[ST-1];
  assign sing_out  = sgr;
  assign en[ST-1]  = !v[ST-1] || out_ready;

  for (genvar k = 0; k < ST - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  always_comb begin
    for (int i = 0; i < N_ELEM; i++) begin
      nh[i] = num[i*NW + O +: HW];
      nl[i] = num[i*NW +: O];
      inv[i*O +: O] = ir[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < ST; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 0: quotient overflow test and first partial remainder
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < N_ELEM; i++) begin
        ovf[0][i] <= (nh[i] >= dm);
        p[0][i]   <= DMW'(nh[i]);
        lo[0][i]  <= nl[i];
        q[0][i]   <= '0;
        cn[0][i]  <= cneg[i];
      end
      dmr[0] <= dm;
      dn[0]  <= dneg;
      sg[0]  <= sing;
    end
  end

  for (genvar k = 1; k <= O; k++) begin : g_step
    logic [DMW:0] t [N_ELEM];
    always_comb begin
      for (int i = 0; i < N_ELEM; i++) t[i] = {p[k-1][i], lo[k-1][i][O-1]};
    end
    always_ff @(posedge clk) begin
      if (en[k]) begin
        for (int i = 0; i < N_ELEM; i++) begin
          if (t[i] >= {1'b0, dmr[k-1]}) begin
            p[k][i] <= DMW'(t[i] - {1'b0, dmr[k-1]});
            q[k][i] <= {q[k-1][i][O-2:0], 1'b1};
          end else begin
            p[k][i] <= DMW'(t[i]);
            q[k][i] <= {q[k-1][i][O-2:0], 1'b0};
          end
          lo[k][i]  <= lo[k-1][i] << 1;
          ovf[k][i] <= ovf[k-1][i];
          cn[k][i]  <= cn[k-1][i];
        end
        dmr[k] <= dmr[k-1];
        dn[k]  <= dn[k-1];
        sg[k]  <= sg[k-1];
      end
    end
  end

  // singular zeroing, sign and saturation
  always_comb begin
    for (int i = 0; i < N_ELEM; i++) begin
      if (sg[O]) begin
        res[i] = '0;
      end else if (cn[O][i] != dn[O]) begin
        if (ovf[O][i] || (q[O][i][O-1] && (|q[O][i][O-2:0]))) res[i] = LIM;
        else res[i] = -q[O][i];
      end else begin
        if (ovf[O][i] || q[O][i][O-1]) res[i] = ~LIM;
        else res[i] = q[O][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST-1]) begin
      ir  <= res;
      sgr <= sg[O];
    end
  end

endmodule

`default_nettype wire

@@ rtl/m3i_checker.sv @@
// ---------------------------------------------------------------------------
// m3i_checker
// port-level checks on the inverse pipeline, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

module m3i_checker import m3i_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int OUT_WIDTH = OUT_WIDTH_DEF
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_axis_tvalid,
  input logic                                  s_axis_tready,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [((N_ELEM*OUT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input logic [0:0]                            m_axis_tuser
);

  // output valid held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped under stall");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // input only refused when every stage is full behind a stalled output
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused with room in the pipeline");

  // singular results carry a zero inverse
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("singular result with nonzero inverse");

endmodule

bind matrix3x3_inverse m3i_checker #(
  .IN_WIDTH  (IN_WIDTH),
  .OUT_WIDTH (OUT_WIDTH)
) u_m3i_checker (.*);

`default_nettype wire

@@ tb/sv/matrix3x3_inverse_test.sv @@
// ---------------------------------------------------------------------------
// matrix3x3_inverse_test
// self-checking bench for the 3x3 inverse: directed matrices, then random
// streams under bursty input and stalled output, checked against a predictor
// ---------------------------------------------------------------------------
`default_nettype none

module matrix3x3_inverse_test;
  import m3i_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW = IN_WIDTH_DEF;
  localparam int OW = OUT_WIDTH_DEF;
  localparam int LATENCY = OW + 8;
  localparam int N_RANDOM = 500;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [IW-1:0] entry_t;
  typedef logic signed [OW-1:0] inv_t;

  typedef struct packed {
    logic              singular;
    logic [N_ELEM*OW-1:0] inv;
  } inverse_t;

  // directed row: matrix and optional typed-in answer
  typedef struct {
    entry_t  m[N_ELEM];
    bit      known;
    inverse_t answer;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [N_ELEM*IW-1:0] s_axis_tdata = '0;   // m_r0c0 .. m_r2c2, lowest first
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [N_ELEM*OW-1:0] m_axis_tdata;        // inv_r0c0 .. inv_r2c2, lowest first
  logic [0:0] m_axis_tuser;                  // is_singular
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr = '0;
  logic [PDATA_WIDTH-1:0] pwdata = '0;
  logic [PDATA_WIDTH-1:0] prdata;
  logic pready;

  matrix3x3_inverse i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [THR_WIDTH-1:0] threshold_model = '0;
  inverse_t pending_inverses[$];
  int errors = 0;
  longint cycles = 0;
  bit long_hold = 0;   // receiver forced off for a long stretch
  bit stall_pattern = 0;

  // rounded, saturated cof * 2^28 / det
  function automatic inv_t scaled_quotient(longint signed cof, longint signed det);
    logic [127:0] num, dm, q;
    bit neg;
    num = (cof < 0) ? -cof : cof;
    dm = (det < 0) ? -det : det;
    num = num << FRAC_SHIFT;
    q = (num + (dm >> 1)) / dm;
    neg = (cof < 0) != (det < 0);
    if (neg) begin
      if (q > (128'd1 << (OW - 1))) q = 128'd1 << (OW - 1);
      return inv_t'(-q);
    end
    if (q > (128'd1 << (OW - 1)) - 1) q = (128'd1 << (OW - 1)) - 1;
    return inv_t'(q);
  endfunction

  function automatic inverse_t predict_inverse(input logic [N_ELEM*IW-1:0] packed_m);
    longint signed e[N_ELEM];
    longint signed cof[N_ELEM];
    longint signed det;
    logic [63:0] dm;
    inverse_t r;
    for (int i = 0; i < N_ELEM; i++) e[i] = entry_t'(packed_m[i*IW +: IW]);
    cof[0] = e[4]*e[8] - e[5]*e[7];
    cof[1] = e[2]*e[7] - e[1]*e[8];
    cof[2] = e[1]*e[5] - e[2]*e[4];
    cof[3] = e[5]*e[6] - e[3]*e[8];
    cof[4] = e[0]*e[8] - e[2]*e[6];
    cof[5] = e[2]*e[3] - e[0]*e[5];
    cof[6] = e[3]*e[7] - e[6]*e[4];
    cof[7] = e[1]*e[6] - e[0]*e[7];
    cof[8] = e[0]*e[4] - e[1]*e[3];
    det = e[0]*cof[0] + e[1]*cof[3] + e[2]*cof[6];
    dm = (det < 0) ? -det : det;
    r = '0;
    if (dm <= {16'd0, threshold_model} || dm == 0) begin
      r.singular = 1'b1;
    end else begin
      for (int i = 0; i < N_ELEM; i++) r.inv[i*OW +: OW] = scaled_quotient(cof[i], det);
    end
    return r;
  endfunction

  // register write over apb, block idle
  task automatic write_threshold(input logic [THR_WIDTH-1:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= PADDR_WIDTH'(REG_DET_THRESHOLD) * 8;
    pwdata <= PDATA_WIDTH'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    threshold_model = value;
  endtask

  task automatic drain;
    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // one transaction; expectation queued when it is accepted
  task automatic send_matrix(input logic [N_ELEM*IW-1:0] m, input bit known,
                             input inverse_t answer);
    inverse_t exp_inv;
    exp_inv = predict_inverse(m);
    if (known && exp_inv !== answer)
      $display("%0t note: directed answer differs from predictor", $time);
    s_axis_tdata <= m;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_inverses.push_back(known ? answer : exp_inv);
  endtask

  function automatic logic [N_ELEM*IW-1:0] pack_matrix(input entry_t m[N_ELEM]);
    logic [N_ELEM*IW-1:0] p;
    for (int i = 0; i < N_ELEM; i++) p[i*IW +: IW] = m[i];
    return p;
  endfunction

  // random matrix: mix of full-range, mid-range, small-valued, small-diagonal and exactly singular
  function automatic logic [N_ELEM*IW-1:0] random_matrix;
    entry_t m[N_ELEM];
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < N_ELEM; i++) begin
      if (kind < 4) m[i] = entry_t'($urandom);
      else if (kind < 7) m[i] = entry_t'($urandom_range(0, 16384)) - 16'sd8192;
      else m[i] = entry_t'($urandom_range(0, 64)) - 16'sd32;
    end
    if (kind == 9) begin
      // duplicated row: exactly singular
      for (int c = 0; c < 3; c++) m[6 + c] = m[c];
    end else if (kind == 8) begin
      // random small diagonal: large entries of the inverse
      for (int i = 0; i < N_ELEM; i++) m[i] = (i % 4 == 0) ? entry_t'($urandom_range(1, 8)) : 0;
    end
    return pack_matrix(m);
  endfunction

  // result checking
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_inverses.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h %b", $time,
                 m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        inverse_t e;
        e = pending_inverses.pop_front();
        if (m_axis_tuser[0] !== e.singular) begin
          $display("%0t is_singular mismatch: expected %b actual %b", $time,
                   e.singular, m_axis_tuser[0]);
          errors++;
        end
        for (int i = 0; i < N_ELEM; i++)
          if (m_axis_tdata[i*OW +: OW] !== e.inv[i*OW +: OW]) begin
            $display("%0t inv_r%0dc%0d mismatch: expected %0d actual %0d", $time, i / 3, i % 3,
                     $signed(e.inv[i*OW +: OW]), $signed(m_axis_tdata[i*OW +: OW]));
            errors++;
          end
      end
    end
  end

  // receiver: own stall pattern, or a long hold-off when asked
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (long_hold) m_axis_tready <= 1'b0;
    else if (!stall_pattern) m_axis_tready <= 1'b1;
    else m_axis_tready <= (stall_phase % 7 < 4) ? ($urandom_range(0, 3) != 0)
                                                : 1'($urandom_range(0, 1));
  end

  // timeout guard
  always @(posedge clk)
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL matrix3x3_inverse");
      $finish;
    end

  vector_t directed[$];

  task automatic add_row(input entry_t a[N_ELEM], input bit known, input inverse_t ans);
    vector_t v;
    v.m = a; v.known = known; v.answer = ans;
    directed.push_back(v);
  endtask

  initial begin
    entry_t a[N_ELEM];
    inverse_t ans;
    logic [THR_WIDTH-1:0] thresholds[5];
    int burst;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // zero matrix after reset: singular, answer typed in
    a = '{default: 0};
    ans = '0; ans.singular = 1'b1;
    add_row(a, 1, ans);
    // identity: inverse 1.0 on the diagonal
    a = '{16'sd4096, 0, 0, 0, 16'sd4096, 0, 0, 0, 16'sd4096};
    ans = '0;
    for (int i = 0; i < 3; i++) ans.inv[(i*4)*OW +: OW] = 32'sd65536;
    add_row(a, 1, ans);
    // negated identity
    a = '{-16'sd4096, 0, 0, 0, -16'sd4096, 0, 0, 0, -16'sd4096};
    ans = '0;
    for (int i = 0; i < 3; i++) ans.inv[(i*4)*OW +: OW] = -32'sd65536;
    add_row(a, 1, ans);
    // tiny diagonal: large inverse entries, both signs
    a = '{16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1};      add_row(a, 0, '0);
    a = '{-16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1};     add_row(a, 0, '0);
    // extremes of the field range
    a = '{default: 16'sh7fff};                            add_row(a, 0, '0);
    a = '{default: -16'sd32768};                          add_row(a, 0, '0);
    a = '{-16'sd32768, 0, 0, 0, -16'sd32768, 0, 0, 0, -16'sd32768}; add_row(a, 0, '0);
    a = '{16'sh7fff, 0, 0, 0, 16'sh7fff, 0, 0, 0, 16'sh7fff};       add_row(a, 0, '0);
    a = '{16'sh7fff, -16'sd32768, 16'sh7fff, -16'sd32768, 16'sh7fff,
          -16'sd32768, 16'sh7fff, 16'sh7fff, -16'sd32768};          add_row(a, 0, '0);
    // rank-deficient and general cases
    a = '{16'sd4096, 16'sd8192, 16'sd12288, 16'sd4096, 16'sd8192, 16'sd12288, 1, 2, 3};
    add_row(a, 0, '0);
    a = '{16'sd2, 16'sd1, 0, 16'sd1, 16'sd3, 16'sd1, 0, 16'sd1, 16'sd4}; add_row(a, 0, '0);
    a = '{16'sd3, 0, 0, 0, 16'sd3, 0, 0, 0, 16'sd3};                     add_row(a, 0, '0);
    a = '{0, 16'sd4096, 0, 0, 0, 16'sd4096, 16'sd4096, 0, 0};            add_row(a, 0, '0);
    a = '{16'sd1234, -16'sd567, 16'sd89, 16'sd4321, 16'sd765, -16'sd98,
          -16'sd11, 16'sd2222, 16'sd3333};                                add_row(a, 0, '0);

    foreach (directed[k])
      send_matrix(pack_matrix(directed[k].m), directed[k].known, directed[k].answer);
    s_axis_tvalid <= 1'b0;
    drain();

    // threshold settings, extremes included; random part spread across them
    thresholds = '{48'd1, 48'd4096 << 24, 48'hffff_ffff_ffff, 48'd12345, 48'd0};
    stall_pattern = 1;
    foreach (thresholds[t]) begin
      write_threshold(thresholds[t]);
      for (int n = 0; n < N_RANDOM / 5; ) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && n < N_RANDOM / 5; b++, n++) begin
          // long hold-off while input keeps flowing, in one phase
          if (t == 1 && n == 10) begin
            fork
              begin
                long_hold = 1;
                repeat (3 * LATENCY) @(posedge clk);
                long_hold = 0;
              end
            join_none
          end
          send_matrix(random_matrix(), 0, '0);
        end
        s_axis_tvalid <= 1'b0;
        if (t == 3 && n > 50 && n < 80) drain();   // sender waits for all results
        else repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      drain();
      stall_pattern = (t % 2 == 0);
    end

    if (errors == 0) $display("PASS matrix3x3_inverse");
    else $display("FAIL matrix3x3_inverse");
    $finish;
  end

  // leftovers keep drain waiting on the queue until the timeout guard reports a failure
endmodule

`default_nettype wire
